>>> src/bedu_pkg.sv
package bedu_pkg;

    // Width of one character.
    localparam int CH_W = 8;

    // Width of a distance result and of the cutoff register.
    localparam int DIST_W = 7;

    // Width of a matrix entry inside the cell chain. It covers the longest
    // word that the length parameter allows.
    localparam int ROW_W = 8;

    // Largest distance that the result field can show.
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Cutoff value after reset.
    localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(1);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_REF   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_END   = 2'd3
    } func_t;

    // Wavefront data that one cell hands to the next.
    typedef struct packed {
        logic             tok;
        logic             done;
        logic [ROW_W-1:0] left;
        logic [ROW_W-1:0] diag;
        logic [ROW_W-1:0] rmin;
    } link_t;

    // Controls broadcast from the top level to every cell.
    typedef struct packed {
        logic            restart;
        logic            append;
        logic [CH_W-1:0] ch_ref;
        logic [CH_W-1:0] ch_q;
    } cell_ctl_t;

endpackage

>>> src/bounded_edit_distance_unit.sv
// Bounded edit distance unit.
// Items enter on the request channel (req_valid, req_stall) with a function
// code and a character. Clear empties the reference, the query and the
// overflow flag; a reference character is appended to the stored word (or sets
// overflow when full) and restarts the query; a query character computes one
// more row of the distance matrix; an end item returns distance, too_far and
// overflow on the result channel (res_valid, res_stall) and rearms the query.
// A query character walks down a row of cells, one column per cycle, and
// keeps the block busy until the last column is done; every other item, and
// a query character that is ignored or dropped, leaves the block free.
// The result of an end item is shown in the cycle after its transfer and
// stays until it is taken. Other items keep flowing while a result waits;
// a further end item is held off until the waiting result has been taken.
// The cutoff register is written through cfg_wr_en and cfg_wr_data.
// Reset empties the reference and the query, clears both flags and sets the
// cutoff to 1; no clearing pass is needed.
module bounded_edit_distance_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    func,
    input  logic [bedu_pkg::CH_W-1:0]     ch,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [bedu_pkg::DIST_W-1:0]   distance,
    output logic                          too_far,
    output logic                          overflow,
    input  logic                          cfg_wr_en,
    input  logic [bedu_pkg::DIST_W-1:0]   cfg_wr_data
);
    import bedu_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [LEN_W-1:0]  ref_len_reg;
    logic [LEN_W-1:0]  ref_len_next;
    logic [LEN_W-1:0]  qlen_reg;
    logic [LEN_W-1:0]  qlen_next;
    logic              stopped_reg;
    logic              stopped_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              busy_reg;
    logic              busy_next;
    logic [DIST_W-1:0] max_dist_reg;
    logic [DIST_W-1:0] max_dist_next;
    logic [ROW_W-1:0]  final_reg;
    logic [ROW_W-1:0]  final_next;
    logic [CH_W-1:0]   qch_reg;
    logic [CH_W-1:0]   qch_next;
    logic              inj_tok_reg;
    logic              inj_tok_next;
    logic [ROW_W-1:0]  inj_left_reg;
    logic [ROW_W-1:0]  inj_left_next;
    logic [ROW_W-1:0]  inj_diag_reg;
    logic [ROW_W-1:0]  inj_diag_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [DIST_W-1:0] distance_reg;
    logic [DIST_W-1:0] distance_next;
    logic              too_far_reg;
    logic              too_far_next;
    logic              overflow_reg;
    logic              overflow_next;

    logic              accept;
    func_t             op;
    cell_ctl_t         ctl;
    link_t             link [0:MAX_LEN];
    logic              done_any;
    logic [ROW_W-1:0]  sel_val;
    logic [ROW_W-1:0]  sel_min;

    assign op        = func_t'(func);
    assign req_stall = busy_reg || (op == FUNC_END && res_valid_reg);
    assign accept    = req_valid && !req_stall;

    assign link[0] = '{tok: inj_tok_reg, done: 1'b0, left: inj_left_reg,
                       diag: inj_diag_reg, rmin: '1};

    for (genvar j = 1; j <= MAX_LEN; j++)
    begin : g_cell
        bedu_cell #(
            .IDX(j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .sel_wr   (ref_len_reg == LEN_W'(j - 1)),
            .is_last  (ref_len_reg == LEN_W'(j)),
            .link_in  (link[j-1]),
            .link_out (link[j])
        );
    end

    // Only one token is in the chain, so at most one cell reports done.
    always_comb
    begin
        done_any = 1'b0;
        sel_val  = '0;
        sel_min  = '0;
        for (int j = 1; j <= MAX_LEN; j++)
        begin
            done_any = done_any | link[j].done;
            if (link[j].done)
            begin
                sel_val = sel_val | link[j].left;
                sel_min = sel_min | link[j].rmin;
            end
        end
    end

    always_comb
    begin
        ref_len_next   = ref_len_reg;
        qlen_next      = qlen_reg;
        stopped_next   = stopped_reg;
        ovf_next       = ovf_reg;
        busy_next      = busy_reg;
        max_dist_next  = max_dist_reg;
        final_next     = final_reg;
        qch_next       = qch_reg;
        inj_tok_next   = 1'b0;
        inj_left_next  = inj_left_reg;
        inj_diag_next  = inj_diag_reg;
        res_valid_next = res_valid_reg && res_stall;
        distance_next  = distance_reg;
        too_far_next   = too_far_reg;
        overflow_next  = overflow_reg;
        ctl            = '{restart: 1'b0, append: 1'b0, ch_ref: ch, ch_q: qch_reg};

        if (cfg_wr_en)
        begin
            max_dist_next = cfg_wr_data;
        end

        if (done_any)
        begin
            busy_next  = 1'b0;
            final_next = sel_val;
            if (sel_min > ROW_W'(max_dist_reg))
            begin
                stopped_next = 1'b1;
            end
        end

        if (accept)
        begin
            unique case (op)
                FUNC_CLEAR:
                begin
                    ref_len_next = '0;
                    ovf_next     = 1'b0;
                    ctl.restart  = 1'b1;
                    qlen_next    = '0;
                    stopped_next = 1'b0;
                    final_next   = '0;
                end
                FUNC_REF:
                begin
                    ctl.restart  = 1'b1;
                    qlen_next    = '0;
                    stopped_next = 1'b0;
                    if (ref_len_reg < LEN_W'(MAX_LEN))
                    begin
                        ctl.append   = 1'b1;
                        ref_len_next = ref_len_reg + LEN_W'(1);
                        final_next   = ROW_W'(ref_len_reg) + ROW_W'(1);
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        final_next = ROW_W'(ref_len_reg);
                    end
                end
                FUNC_QUERY:
                begin
                    if (!stopped_reg)
                    begin
                        if (qlen_reg >= LEN_W'(MAX_LEN))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            qlen_next = qlen_reg + LEN_W'(1);
                            // With no reference columns the row is empty and
                            // counts as past the cutoff.
                            if (ref_len_reg == '0)
                            begin
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                busy_next     = 1'b1;
                                qch_next      = ch;
                                inj_tok_next  = 1'b1;
                                inj_left_next = ROW_W'(qlen_reg) + ROW_W'(1);
                                inj_diag_next = ROW_W'(qlen_reg);
                            end
                        end
                    end
                end
                FUNC_END:
                begin
                    res_valid_next = 1'b1;
                    too_far_next   = stopped_reg;
                    overflow_next  = ovf_reg;
                    if (stopped_reg)
                    begin
                        distance_next = '0;
                    end
                    else if (final_reg > ROW_W'(DIST_MAX))
                    begin
                        distance_next = DIST_MAX;
                    end
                    else
                    begin
                        distance_next = final_reg[DIST_W-1:0];
                    end
                    ctl.restart  = 1'b1;
                    qlen_next    = '0;
                    stopped_next = 1'b0;
                    final_next   = ROW_W'(ref_len_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg   <= '0;
            qlen_reg      <= '0;
            stopped_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            max_dist_reg  <= MAX_DIST_RESET;
            final_reg     <= '0;
            inj_tok_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ref_len_reg   <= ref_len_next;
            qlen_reg      <= qlen_next;
            stopped_reg   <= stopped_next;
            ovf_reg       <= ovf_next;
            busy_reg      <= busy_next;
            max_dist_reg  <= max_dist_next;
            final_reg     <= final_next;
            inj_tok_reg   <= inj_tok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qch_reg      <= qch_next;
        inj_left_reg <= inj_left_next;
        inj_diag_reg <= inj_diag_next;
        distance_reg <= distance_next;
        too_far_reg  <= too_far_next;
        overflow_reg <= overflow_next;
    end

    // Cell values and reference characters are not reset. The reference character
    // that first brings a column into use also restarts every column before a token can run.
    assign res_valid = res_valid_reg;
    assign distance  = distance_reg;
    assign too_far   = too_far_reg;
    assign overflow  = overflow_reg;

endmodule

>>> src/bedu_cell.sv
module bedu_cell #(
    parameter int IDX = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bedu_pkg::cell_ctl_t  ctl,
    input  logic                 sel_wr,
    input  logic                 is_last,
    input  bedu_pkg::link_t      link_in,
    output bedu_pkg::link_t      link_out
);
    import bedu_pkg::*;

    logic [CH_W-1:0]  ref_ch_reg;
    logic [CH_W-1:0]  ref_ch_next;
    logic [ROW_W-1:0] value_reg;
    logic [ROW_W-1:0] value_next;
    link_t            out_reg;
    link_t            out_next;
    logic [ROW_W-1:0] best;
    logic [ROW_W-1:0] cost;

    // The cell holds one column of the current row. A token from the left
    // brings the new value of the previous column and its old value.
    always_comb
    begin
        best = value_reg;
        if (link_in.left < best)
        begin
            best = link_in.left;
        end
        if (link_in.diag < best)
        begin
            best = link_in.diag;
        end
        if (ref_ch_reg == ctl.ch_q)
        begin
            cost = link_in.diag;
        end
        else
        begin
            cost = best + ROW_W'(1);
        end
    end

    always_comb
    begin
        ref_ch_next = ref_ch_reg;
        value_next  = value_reg;
        out_next    = out_reg;
        if (ctl.append && sel_wr)
        begin
            ref_ch_next = ctl.ch_ref;
        end
        if (ctl.restart)
        begin
            value_next = ROW_W'(IDX);
        end
        else if (link_in.tok)
        begin
            value_next = cost;
        end
        out_next.tok  = link_in.tok && !is_last;
        out_next.done = link_in.tok && is_last;
        if (link_in.tok)
        begin
            out_next.left = cost;
            out_next.diag = value_reg;
            out_next.rmin = (cost < link_in.rmin) ? cost : link_in.rmin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_ch_reg    <= ref_ch_next;
        value_reg     <= value_next;
    end

    assign link_out = out_reg;

endmodule

>>> src/bedu_checker.sv
module bedu_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic [1:0]                    func,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [bedu_pkg::DIST_W-1:0]   distance,
    input logic                          too_far,
    input logic                          overflow
);
    import bedu_pkg::*;

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(distance)
            && $stable(too_far) && $stable(overflow))
    else $error("result changed while stalled");

    // An abandoned comparison reports a distance of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && too_far |-> distance == '0)
    else $error("too_far result with nonzero distance");

    // An end item that is transferred produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && func == FUNC_END |=> res_valid)
    else $error("end item without result");

    // A new result only follows the transfer of an end item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid && res_stall)
            |-> $past(req_valid && !req_stall && func == FUNC_END))
    else $error("result without end item");

endmodule

bind bounded_edit_distance_unit bedu_checker u_bedu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .distance  (distance),
    .too_far   (too_far),
    .overflow  (overflow)
);
